// File: rtl/rtms_pkg.sv
// shared types and constants for the range table membership search core
package rtms_pkg;

  localparam int CP_W              = 21;
  localparam int CNT_CFG_W         = 11;
  localparam int IDX_W             = 10;
  localparam int MAX_DEPTH_W       = 17;
  localparam int DEFAULT_TABLE_DEPTH = 1024;
  localparam int PADDR_W           = 4;
  localparam int PDATA_W           = 32;

  localparam logic [CP_W-1:0] DOMAIN_LIMIT_RST = 21'h00ffff;

  localparam logic [1:0] REG_RANGE_COUNT  = 2'd0;
  localparam logic [1:0] REG_COMPLEMENT   = 2'd1;
  localparam logic [1:0] REG_DOMAIN_LIMIT = 2'd2;

  localparam logic KIND_LOAD  = 1'b0;
  localparam logic KIND_QUERY = 1'b1;

  typedef struct packed {
    logic [CNT_CFG_W-1:0] range_count;
    logic                 complement_mode;
    logic [CP_W-1:0]      domain_limit;
  } cfg_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SEARCH,
    ST_RESULT
  } state_t;

endpackage

// File: rtl/range_table_membership_search_core.sv
// top level of the range table membership search core
//
//   port group  dir   carries
//   in_*        in    load beat (slot, low, high) or query beat (code point)
//   out_*       out   one membership bit per query beat
//   p*          cfg   range_count, complement_mode, domain_limit registers
//
// a load beat takes one cycle; a query result comes at most 2 + ceil(log2(n+1))
// cycles after its beat for n searched entries (13 at 1024), one table read per
// probe step, and in_ready returns the cycle after the result is registered
// the table has no reset and must be loaded before it is searched
// a finished result waits in the output register; the next beat is taken
// meanwhile, and a later query holds in its result state until out is free
module range_table_membership_search_core
  import rtms_pkg::*;
#(
  parameter int TABLE_DEPTH = DEFAULT_TABLE_DEPTH
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [PDATA_W-1:0] pwdata,
  output logic [PDATA_W-1:0] prdata,
  output logic               pready,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic               in_kind,
  input  logic [IDX_W-1:0]   in_entry_index,
  input  logic [CP_W-1:0]    in_range_low,
  input  logic [CP_W-1:0]    in_range_high,
  input  logic [CP_W-1:0]    in_code_point,
  output logic               out_valid,
  input  logic               out_ready,
  output logic               out_is_member
);

  localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;

  cfg_t            cfg;
  logic            mem_wr_en;
  logic [AW-1:0]   mem_wr_addr;
  logic [CP_W-1:0] mem_wr_lo;
  logic [CP_W-1:0] mem_wr_hi;
  logic            mem_rd_en;
  logic [AW-1:0]   mem_rd_addr;
  logic [CP_W-1:0] mem_rd_lo;
  logic [CP_W-1:0] mem_rd_hi;

  rtms_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  rtms_mem #(
    .TABLE_DEPTH (TABLE_DEPTH),
    .AW          (AW)
  ) u_mem (
    .clk     (clk),
    .wr_en   (mem_wr_en),
    .wr_addr (mem_wr_addr),
    .wr_lo   (mem_wr_lo),
    .wr_hi   (mem_wr_hi),
    .rd_en   (mem_rd_en),
    .rd_addr (mem_rd_addr),
    .rd_lo   (mem_rd_lo),
    .rd_hi   (mem_rd_hi)
  );

  rtms_ctrl #(
    .TABLE_DEPTH (TABLE_DEPTH),
    .AW          (AW)
  ) u_ctrl (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg            (cfg),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_kind        (in_kind),
    .in_entry_index (in_entry_index),
    .in_range_low   (in_range_low),
    .in_range_high  (in_range_high),
    .in_code_point  (in_code_point),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_is_member  (out_is_member),
    .mem_wr_en      (mem_wr_en),
    .mem_wr_addr    (mem_wr_addr),
    .mem_wr_lo      (mem_wr_lo),
    .mem_wr_hi      (mem_wr_hi),
    .mem_rd_en      (mem_rd_en),
    .mem_rd_addr    (mem_rd_addr),
    .mem_rd_lo      (mem_rd_lo),
    .mem_rd_hi      (mem_rd_hi)
  );

endmodule

// File: rtl/rtms_cfg.sv
// configuration registers behind the apb-style port
module rtms_cfg
  import rtms_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [PDATA_W-1:0] pwdata,
  output logic [PDATA_W-1:0] prdata,
  output logic               pready,
  output cfg_t               cfg
);

  logic [CNT_CFG_W-1:0] range_count_r;
  logic                 complement_r;
  logic [CP_W-1:0]      domain_limit_r;
  logic                 wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      range_count_r  <= '0;
      complement_r   <= 1'b0;
      domain_limit_r <= DOMAIN_LIMIT_RST;
    end else if (wr_en) begin
      unique case (paddr[3:2])
        REG_RANGE_COUNT:  range_count_r  <= pwdata[CNT_CFG_W-1:0];
        REG_COMPLEMENT:   complement_r   <= pwdata[0];
        REG_DOMAIN_LIMIT: domain_limit_r <= pwdata[CP_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      REG_RANGE_COUNT:  prdata = PDATA_W'(range_count_r);
      REG_COMPLEMENT:   prdata = PDATA_W'(complement_r);
      REG_DOMAIN_LIMIT: prdata = PDATA_W'(domain_limit_r);
      default:          prdata = '0;
    endcase
  end

  assign cfg.range_count     = range_count_r;
  assign cfg.complement_mode = complement_r;
  assign cfg.domain_limit    = domain_limit_r;

endmodule

// File: rtl/rtms_mem.sv
// range table memory, one write port and one registered read port
module rtms_mem
  import rtms_pkg::*;
#(
  parameter int TABLE_DEPTH = DEFAULT_TABLE_DEPTH,
  parameter int AW          = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1
) (
  input  logic            clk,
  input  logic            wr_en,
  input  logic [AW-1:0]   wr_addr,
  input  logic [CP_W-1:0] wr_lo,
  input  logic [CP_W-1:0] wr_hi,
  input  logic            rd_en,
  input  logic [AW-1:0]   rd_addr,
  output logic [CP_W-1:0] rd_lo,
  output logic [CP_W-1:0] rd_hi
);

  logic [2*CP_W-1:0] mem [TABLE_DEPTH];
  logic [2*CP_W-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= {wr_hi, wr_lo};
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_lo = rd_data_r[CP_W-1:0];
  assign rd_hi = rd_data_r[2*CP_W-1:CP_W];

endmodule

// File: rtl/rtms_ctrl.sv
// search sequencer, load path and result register
module rtms_ctrl
  import rtms_pkg::*;
#(
  parameter int TABLE_DEPTH = DEFAULT_TABLE_DEPTH,
  parameter int AW          = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1
) (
  input  logic             clk,
  input  logic             rst_n,
  input  cfg_t             cfg,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic             in_kind,
  input  logic [IDX_W-1:0] in_entry_index,
  input  logic [CP_W-1:0]  in_range_low,
  input  logic [CP_W-1:0]  in_range_high,
  input  logic [CP_W-1:0]  in_code_point,
  output logic             out_valid,
  input  logic             out_ready,
  output logic             out_is_member,
  output logic             mem_wr_en,
  output logic [AW-1:0]    mem_wr_addr,
  output logic [CP_W-1:0]  mem_wr_lo,
  output logic [CP_W-1:0]  mem_wr_hi,
  output logic             mem_rd_en,
  output logic [AW-1:0]    mem_rd_addr,
  input  logic [CP_W-1:0]  mem_rd_lo,
  input  logic [CP_W-1:0]  mem_rd_hi
);

  localparam int CW = $clog2(TABLE_DEPTH + 1);

  state_t          state_r, state_nxt;
  logic [CP_W-1:0] cp_r;
  logic            compl_r;
  logic            over_r, over_nxt;
  logic [CW-1:0]   lo_r, lo_nxt;
  logic [CW-1:0]   hi_r, hi_nxt;
  logic [CW-1:0]   mid_r, mid_nxt;
  logic            pend_r, pend_nxt;
  logic            found_r, found_nxt;
  logic            out_valid_r;
  logic            out_member_r;

  logic            in_beat;
  logic            query_beat;
  logic [CW-1:0]   n_sat;
  logic            cp_below, cp_above, hit;
  logic [CW-1:0]   step_lo, step_hi;
  logic            step_more;
  logic [CW:0]     mid_sum;
  logic            out_free;

  assign in_ready   = (state_r == ST_IDLE);
  assign in_beat    = in_valid & in_ready;
  assign query_beat = in_beat & (in_kind == KIND_QUERY);
  assign out_free   = ~out_valid_r | out_ready;

  assign n_sat = (MAX_DEPTH_W'(cfg.range_count) > MAX_DEPTH_W'(TABLE_DEPTH))
               ? CW'(TABLE_DEPTH) : CW'(cfg.range_count);

  // load beats write straight into the table
  assign mem_wr_en   = in_beat & (in_kind == KIND_LOAD) &
                       (MAX_DEPTH_W'(in_entry_index) < MAX_DEPTH_W'(TABLE_DEPTH));
  assign mem_wr_addr = AW'(in_entry_index);
  assign mem_wr_lo   = in_range_low;
  assign mem_wr_hi   = in_range_high;

  // one search step: compare fetched entry, narrow bounds, pick next probe
  always_comb begin
    cp_below = cp_r < mem_rd_lo;
    cp_above = cp_r > mem_rd_hi;
    hit      = pend_r & ~cp_below & ~cp_above;
    step_lo  = lo_r;
    step_hi  = hi_r;
    if (pend_r) begin
      if (cp_below) begin
        step_hi = mid_r;
      end else if (cp_above) begin
        step_lo = mid_r + CW'(1);
      end
    end
    step_more = ~hit & (step_lo < step_hi);
    mid_sum   = {1'b0, step_lo} + {1'b0, step_hi};
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (query_beat) begin
          state_nxt = ST_SEARCH;
        end
      end
      ST_SEARCH: begin
        if (over_r || !step_more) begin
          state_nxt = ST_RESULT;
        end
      end
      ST_RESULT: begin
        if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    lo_nxt      = lo_r;
    hi_nxt      = hi_r;
    mid_nxt     = mid_r;
    pend_nxt    = pend_r;
    found_nxt   = found_r;
    over_nxt    = over_r;
    mem_rd_en   = 1'b0;
    mem_rd_addr = mid_sum[AW:1];
    unique case (state_r)
      ST_IDLE: begin
        if (query_beat) begin
          lo_nxt    = '0;
          hi_nxt    = n_sat;
          pend_nxt  = 1'b0;
          found_nxt = 1'b0;
          over_nxt  = cfg.complement_mode & (in_code_point > cfg.domain_limit);
        end
      end
      ST_SEARCH: begin
        lo_nxt    = step_lo;
        hi_nxt    = step_hi;
        found_nxt = hit;
        mid_nxt   = mid_sum[CW:1];
        pend_nxt  = step_more & ~over_r;
        mem_rd_en = step_more & ~over_r;
      end
      ST_RESULT: ;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      pend_r  <= pend_nxt;
      if (state_r == ST_RESULT && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    lo_r    <= lo_nxt;
    hi_r    <= hi_nxt;
    mid_r   <= mid_nxt;
    found_r <= found_nxt;
    over_r  <= over_nxt;
    if (query_beat) begin
      cp_r    <= in_code_point;
      compl_r <= cfg.complement_mode;
    end
    if (state_r == ST_RESULT && out_free) begin
      out_member_r <= ~over_r & (compl_r ^ found_r);
    end
  end

  assign out_valid     = out_valid_r;
  assign out_is_member = out_member_r;

endmodule

// File: verif/range_table_membership_search_core_tb.sv
// self-checking testbench for the range table membership search core
`timescale 1ns / 1ps

module range_table_membership_search_core_tb;
  import rtms_pkg::*;

  localparam int TABLE_DEPTH   = DEFAULT_TABLE_DEPTH;
  localparam int MAX_CP        = 32'h10FFFF;
  localparam int SETTLE_CYCLES = 24;
  localparam int RANDOM_BEATS  = 630;
  localparam int MAX_COUNT     = (1 << CNT_CFG_W) - 1;

  typedef struct packed {
    logic             kind;
    logic [IDX_W-1:0] entry_index;
    logic [CP_W-1:0]  range_low;
    logic [CP_W-1:0]  range_high;
    logic [CP_W-1:0]  code_point;
  } beat_t;

  typedef enum int {
    TBL_SORTED,
    TBL_WITH_INVERTED,
    TBL_SCRAMBLED
  } table_style_t;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               psel = 1'b0;
  logic               penable = 1'b0;
  logic               pwrite = 1'b0;
  logic [PADDR_W-1:0] paddr = '0;
  logic [PDATA_W-1:0] pwdata = '0;
  logic [PDATA_W-1:0] prdata;
  logic               pready;
  logic               in_valid = 1'b0;
  logic               in_ready;
  logic               in_kind = KIND_LOAD;
  logic [IDX_W-1:0]   in_entry_index = '0;
  logic [CP_W-1:0]    in_range_low = '0;
  logic [CP_W-1:0]    in_range_high = '0;
  logic [CP_W-1:0]    in_code_point = '0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic               out_is_member;

  range_table_membership_search_core #(
    .TABLE_DEPTH(TABLE_DEPTH)
  ) u_dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_kind       (in_kind),
    .in_entry_index(in_entry_index),
    .in_range_low  (in_range_low),
    .in_range_high (in_range_high),
    .in_code_point (in_code_point),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_is_member (out_is_member)
  );

  // mirror of the block state used for prediction
  cfg_t            cfg_m = '{range_count: '0, complement_mode: 1'b0,
                             domain_limit: DOMAIN_LIMIT_RST};
  logic [CP_W-1:0] tbl_lo [TABLE_DEPTH];
  logic [CP_W-1:0] tbl_hi [TABLE_DEPTH];

  // what the stimulus side believes the table holds
  logic [CP_W-1:0] plan_lo [TABLE_DEPTH];
  logic [CP_W-1:0] plan_hi [TABLE_DEPTH];

  // slots below this one have all been loaded
  int    filled = 0;
  // lower bounds of the ranges on the leftmost probe path
  int    path_lo [$];

  beat_t input_beats [$];
  logic  expected_member_bits [$];
  beat_t live_beat;
  int    beats_sent = 0;
  int    beats_taken = 0;
  int    fail_count = 0;
  int    in_gap = 0;
  int    out_stall = 0;
  bit    in_quiet = 1'b0;
  bit    out_quiet = 1'b0;

  initial begin
    forever #5 clk = ~clk;
  end

  initial begin
    #15_000_000;
    $display("Test completed with failures");
    $finish;
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic search_membership(input logic [CP_W-1:0] cp);
    int unsigned n, lo_i, hi_i, mid;
    logic        found;
    n = int'(cfg_m.range_count);
    if (n > TABLE_DEPTH) n = TABLE_DEPTH;
    lo_i  = 0;
    hi_i  = n;
    found = 1'b0;
    while (lo_i < hi_i && !found) begin
      mid = lo_i + (hi_i - lo_i) / 2;
      if (cp < tbl_lo[mid]) hi_i = mid;
      else if (cp > tbl_hi[mid]) lo_i = mid + 1;
      else found = 1'b1;
    end
    if (cfg_m.complement_mode) return (cp > cfg_m.domain_limit) ? 1'b0 : !found;
    return found;
  endfunction

  task automatic log_failure(input string msg);
    fail_count++;
    if (fail_count <= 10) $display("%0t: %s", $time, msg);
  endtask

  // input driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        if (live_beat.kind == KIND_LOAD) begin
          if (int'(live_beat.entry_index) < TABLE_DEPTH) begin
            tbl_lo[live_beat.entry_index] = live_beat.range_low;
            tbl_hi[live_beat.entry_index] = live_beat.range_high;
          end
        end else begin
          expected_member_bits.push_back(search_membership(live_beat.code_point));
        end
        beats_taken++;
      end
      if (in_valid && !in_ready) begin
        // hold the beat until taken
      end else if (in_gap > 0) begin
        in_gap--;
        in_valid <= 1'b0;
      end else if (input_beats.size() > 0) begin
        live_beat = input_beats.pop_front();
        in_valid       <= 1'b1;
        in_kind        <= live_beat.kind;
        in_entry_index <= live_beat.entry_index;
        in_range_low   <= live_beat.range_low;
        in_range_high  <= live_beat.range_high;
        in_code_point  <= live_beat.code_point;
        in_gap = in_quiet ? 0 : pick_gap();
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // result monitor
  always @(posedge clk) begin
    logic want;
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (expected_member_bits.size() == 0) begin
          log_failure($sformatf("result beat with no query pending: is_member %0b",
                                out_is_member));
        end else begin
          want = expected_member_bits.pop_front();
          if (out_is_member !== want)
            log_failure($sformatf("is_member mismatch: expected %0b, got %0b",
                                  want, out_is_member));
        end
      end
      if (out_stall > 0) begin
        out_stall--;
        out_ready <= 1'b0;
      end else begin
        if (!out_quiet && $urandom_range(0, 99) < 20) out_stall = pick_gap();
        out_ready <= (out_stall == 0);
      end
    end
  end

  task automatic push_beat(input beat_t b);
    input_beats.push_back(b);
    beats_sent++;
  endtask

  task automatic send_load(input int idx, input int lo, input int hi);
    beat_t b;
    b.kind        = KIND_LOAD;
    b.entry_index = idx[IDX_W-1:0];
    b.range_low   = lo[CP_W-1:0];
    b.range_high  = hi[CP_W-1:0];
    b.code_point  = CP_W'($urandom_range(0, MAX_CP));
    plan_lo[b.entry_index] = b.range_low;
    plan_hi[b.entry_index] = b.range_high;
    if (idx == filled && filled < TABLE_DEPTH) filled++;
    push_beat(b);
  endtask

  task automatic send_query(input int cp);
    beat_t b;
    b.kind        = KIND_QUERY;
    b.entry_index = IDX_W'($urandom_range(0, TABLE_DEPTH - 1));
    b.range_low   = CP_W'($urandom_range(0, MAX_CP));
    b.range_high  = CP_W'($urandom_range(0, MAX_CP));
    b.code_point  = cp[CP_W-1:0];
    push_beat(b);
  endtask

  task automatic drain_and_settle();
    do @(negedge clk);
    while (beats_sent != beats_taken || in_valid || expected_member_bits.size() != 0);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(input logic [1:0] sel, input int value);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= PADDR_W'({sel, 2'b00});
    pwdata  <= PDATA_W'(value);
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk);
    while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (sel)
      REG_RANGE_COUNT:  cfg_m.range_count = value[CNT_CFG_W-1:0];
      REG_COMPLEMENT:   cfg_m.complement_mode = value[0];
      REG_DOMAIN_LIMIT: cfg_m.domain_limit = value[CP_W-1:0];
      default: ;
    endcase
    @(negedge clk);
  endtask

  task automatic load_table(input int n, input table_style_t style);
    int unsigned step, cursor, lo, hi, t;
    step   = (n > 0) ? (MAX_CP + 1) / n : 0;
    cursor = 0;
    for (int k = 0; k < n; k++) begin
      if (style == TBL_SCRAMBLED) begin
        lo = $urandom_range(0, MAX_CP);
        hi = $urandom_range(0, MAX_CP);
      end else begin
        lo = cursor + $urandom_range(0, step / 2);
        hi = lo + $urandom_range(0, step / 2 - 1);
        cursor = hi + 1;
        if (k == 0 && $urandom_range(0, 2) == 0) lo = 0;
        if (k == n - 1 && $urandom_range(0, 2) == 0) hi = MAX_CP;
        if (style == TBL_WITH_INVERTED && lo < hi && $urandom_range(0, 3) == 0) begin
          t  = lo;
          lo = hi;
          hi = t;
        end
      end
      send_load(k, lo, hi);
    end
  endtask

  // contiguous ranges on the slots probed when every step goes low,
  // so a full-size search never leaves that path
  task automatic load_left_path();
    int unsigned hi_i, mid, bound, top;
    hi_i  = TABLE_DEPTH;
    top   = MAX_CP;
    bound = MAX_CP;
    path_lo.delete();
    while (hi_i > 0) begin
      mid   = hi_i / 2;
      bound = bound / 2;
      send_load(mid, bound, top);
      path_lo.push_back(int'(bound));
      top  = bound - 1;
      hi_i = mid;
    end
  endtask

  function automatic int pick_path_point();
    int j, v;
    j = $urandom_range(0, path_lo.size() - 1);
    case ($urandom_range(0, 4))
      0:       v = path_lo[j];
      1:       v = path_lo[j] - 1;
      2:       v = int'(cfg_m.domain_limit) + int'($urandom_range(0, 2)) - 1;
      3:       v = ($urandom_range(0, 1) == 0) ? 0 : MAX_CP;
      default: v = $urandom_range(0, MAX_CP);
    endcase
    if (v < 0) v = 0;
    if (v > MAX_CP) v = MAX_CP;
    return v;
  endfunction

  function automatic int pick_point();
    int n, k, v, r;
    n = int'(cfg_m.range_count);
    if (n > TABLE_DEPTH) n = TABLE_DEPTH;
    r = $urandom_range(0, 99);
    if (n == 0 || r < 15) begin
      case ($urandom_range(0, 3))
        0:       return 0;
        1:       return MAX_CP;
        default: return $urandom_range(0, MAX_CP);
      endcase
    end
    if (r < 25) begin
      v = int'(cfg_m.domain_limit) + int'($urandom_range(0, 2)) - 1;
      if (v < 0) v = 0;
      if (v > MAX_CP) v = MAX_CP;
      return v;
    end
    k = $urandom_range(0, n - 1);
    case ($urandom_range(0, 4))
      0:       return int'(plan_lo[k]);
      1:       return int'(plan_hi[k]);
      2:       return (plan_lo[k] > 0) ? int'(plan_lo[k]) - 1 : int'(plan_lo[k]);
      3:       return (plan_hi[k] < MAX_CP) ? int'(plan_hi[k]) + 1 : int'(plan_hi[k]);
      default: return $urandom_range(plan_lo[k], plan_hi[k]);
    endcase
  endfunction

  initial begin
    int probes [12];
    int n, q, r, cnt, lim, sent_random;
    table_style_t style;

    probes = '{0, 1, 4, 5, 9, 10, 'h50, 'hFFFF, 'h10001, 'hFFFF8, MAX_CP - 1, MAX_CP};
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // empty table, reset configuration
    send_query(0);
    send_query(MAX_CP);
    send_load(0, 0, 0);
    send_load(1, 5, 9);
    send_load(2, 'h41, 'h5A);
    send_load(3, 'hFFFF, 'h10000);
    send_load(4, 'h1FFFF, 'h2FFFF);
    send_load(5, 'h7FFFF, 'h80000);
    send_load(6, 'hFFFFF, 'hFFFF0);
    send_load(7, MAX_CP, MAX_CP);
    drain_and_settle();
    write_reg(REG_RANGE_COUNT, 8);
    foreach (probes[i]) send_query(probes[i]);
    drain_and_settle();
    write_reg(REG_COMPLEMENT, 1);
    send_query('h10000);
    send_query('hFFFF);
    send_query('h100);
    drain_and_settle();

    // count at and past the table size, probes kept on the leftmost path
    in_quiet = 1'b1;
    load_left_path();
    drain_and_settle();
    in_quiet = 1'b0;
    write_reg(REG_RANGE_COUNT, MAX_COUNT);
    write_reg(REG_COMPLEMENT, 0);
    repeat (40) send_query(pick_path_point());
    drain_and_settle();
    write_reg(REG_RANGE_COUNT, TABLE_DEPTH);
    write_reg(REG_COMPLEMENT, 1);
    write_reg(REG_DOMAIN_LIMIT, MAX_CP);
    repeat (20) send_query(pick_path_point());
    drain_and_settle();
    write_reg(REG_RANGE_COUNT, MAX_COUNT);
    write_reg(REG_DOMAIN_LIMIT, $urandom_range(0, MAX_CP));
    repeat (20) send_query(pick_path_point());
    drain_and_settle();

    sent_random = 0;
    while (sent_random < RANDOM_BEATS) begin
      in_quiet  = ($urandom_range(0, 3) == 0);
      out_quiet = ($urandom_range(0, 3) == 0);
      r = $urandom_range(0, 99);
      if (r < 70) n = $urandom_range(1, 16);
      else if (r < 90) n = $urandom_range(17, 128);
      else if (r < 95) n = 0;
      else n = $urandom_range(129, 400);
      r = $urandom_range(0, 99);
      style = (r < 80) ? TBL_SORTED : (r < 90) ? TBL_WITH_INVERTED : TBL_SCRAMBLED;
      load_table(n, style);
      drain_and_settle();

      r = $urandom_range(0, 99);
      if (r < 75) cnt = n;
      else if (r < 85) cnt = $urandom_range(0, filled);
      else if (r < 90) cnt = 0;
      else if (r < 95) cnt = filled;
      else cnt = (n > 0) ? n - 1 : 0;
      case ($urandom_range(0, 3))
        0:       lim = 0;
        1:       lim = MAX_CP;
        2:       lim = DOMAIN_LIMIT_RST;
        default: lim = $urandom_range(0, MAX_CP);
      endcase
      write_reg(REG_RANGE_COUNT, cnt);
      write_reg(REG_COMPLEMENT, $urandom_range(0, 1));
      write_reg(REG_DOMAIN_LIMIT, lim);

      q = $urandom_range(8, 40);
      for (int j = 0; j < q; j++) begin
        if ($urandom_range(0, 99) < 5)
          send_load($urandom_range(0, TABLE_DEPTH - 1), $urandom_range(0, MAX_CP),
                    $urandom_range(0, MAX_CP));
        else
          send_query(pick_point());
        if (j == q / 2 && $urandom_range(0, 3) == 0) drain_and_settle();
      end
      drain_and_settle();
      sent_random += q + n;
    end

    drain_and_settle();
    if (expected_member_bits.size() != 0)
      log_failure($sformatf("%0d query results never arrived",
                            expected_member_bits.size()));
    if (fail_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
